/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the palindrome engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define LPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication under synchronous active-low reset
`define LPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/lps_pkg.sv */
// ----------------------------------------------------------------------------
// Palindrome engine package
// Field widths and fixed constants of the longest palindromic subsequence block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lps_pkg;

    localparam int CHAR_W   = 8;
    localparam int PAL_W    = 11;
    localparam int LEN_MAX  = 2047;
    localparam int PAIR_INC = 2;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [PAL_W-1:0]  t_pal_len;

endpackage

/* rtl/lps_mem.sv */
// ----------------------------------------------------------------------------
// Simple dual-port memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lps_mem #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/lps_cell.sv */
// ----------------------------------------------------------------------------
// Table update cell
// New interval value: inner value plus two on matching ends, else the larger
// of the two shorter intervals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lps_cell #(
    parameter int LEN_W = 11
) (
    input  lps_pkg::t_char    i_char_lo,
    input  lps_pkg::t_char    i_char_hi,
    input  logic [LEN_W-1:0]  i_diag,
    input  logic [LEN_W-1:0]  i_left,
    input  logic [LEN_W-1:0]  i_old,
    output logic [LEN_W-1:0]  o_value
);

    always_comb begin
        if (i_char_lo == i_char_hi) begin
            o_value = LEN_W'(i_diag + LEN_W'(lps_pkg::PAIR_INC));
        end else if (i_left > i_old) begin
            o_value = i_left;
        end else begin
            o_value = i_old;
        end
    end

endmodule

/* rtl/longest_palindromic_subsequence.sv */
// ----------------------------------------------------------------------------
// Longest palindromic subsequence engine
// Stores a byte string, fills the interval table row by row in memory and
// returns the length of the longest palindromic subsequence.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid, o_in_stall, i_char_code,      | to block
//          | i_is_last                                 |
//  out     | o_out_valid, i_out_stall, o_palin_length, | from block
//          | o_overflowed                              |
//
//  Load: one byte per cycle. After the last byte of an n-byte string the
//  table takes n row starts, n-1 row primes and n(n-1)/2 updates, then
//  posts the result; each update is one read-modify-write of the
//  single-read-port row memory. No clearing pass after reset.
//  Input stalls throughout the table fill; the result register lets the next
//  string load while an earlier result waits on a stalled output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module longest_palindromic_subsequence #(
    parameter int MAX_LEN = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  lps_pkg::t_char            i_char_code,
    input  logic                      i_is_last,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output lps_pkg::t_pal_len         o_palin_length,
    output logic                      o_overflowed
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int LW = $clog2(MAX_LEN + 1);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_ROW   = 3'd1;
    localparam logic [2:0] ST_FIRST = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0]              r_state, n_state;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic                    r_ovf, n_ovf;
    logic                    r_fin_ovf, n_fin_ovf;
    logic [AW-1:0]           r_i, n_i;
    logic [AW-1:0]           r_j, n_j;
    logic [AW-1:0]           r_last, n_last;
    lps_pkg::t_char          r_ci, n_ci;
    logic [LW-1:0]           r_diag, n_diag;
    logic [LW-1:0]           r_left, n_left;
    logic [LW-1:0]           r_res, n_res;
    logic                    r_out_valid, n_out_valid;
    lps_pkg::t_pal_len       r_out_len, n_out_len;
    logic                    r_out_ovf, n_out_ovf;

    logic                    full;
    logic                    in_xfer;
    logic                    out_xfer;
    logic                    char_we;
    logic [AW-1:0]           rd_addr;
    lps_pkg::t_char          char_rdata;
    logic                    dp_we;
    logic [AW-1:0]           dp_waddr;
    logic [LW-1:0]           dp_wdata;
    logic [LW-1:0]           dp_rdata;
    logic [LW-1:0]           cell_value;

    assign full       = (r_cnt == CW'(MAX_LEN));
    assign o_in_stall = (r_state != ST_LOAD);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_xfer   = r_out_valid && !i_out_stall;
    assign char_we    = in_xfer && !full;

    lps_mem #(
        .WIDTH  (lps_pkg::CHAR_W),
        .DEPTH  (MAX_LEN),
        .ADDR_W (AW)
    ) u_char_mem (
        .i_clk   (i_clk),
        .i_we    (char_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_char_code),
        .i_raddr (rd_addr),
        .o_rdata (char_rdata)
    );

    lps_mem #(
        .WIDTH  (LW),
        .DEPTH  (MAX_LEN),
        .ADDR_W (AW)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_we    (dp_we),
        .i_waddr (dp_waddr),
        .i_wdata (dp_wdata),
        .i_raddr (rd_addr),
        .o_rdata (dp_rdata)
    );

    lps_cell #(
        .LEN_W (LW)
    ) u_cell (
        .i_char_lo (r_ci),
        .i_char_hi (char_rdata),
        .i_diag    (r_diag),
        .i_left    (r_left),
        .i_old     (dp_rdata),
        .o_value   (cell_value)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_fin_ovf   = r_fin_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_last      = r_last;
        n_ci        = r_ci;
        n_diag      = r_diag;
        n_left      = r_left;
        n_res       = r_res;
        n_out_valid = out_xfer ? 1'b0 : r_out_valid;
        n_out_len   = r_out_len;
        n_out_ovf   = r_out_ovf;
        rd_addr     = r_j;
        dp_we       = 1'b0;
        dp_waddr    = r_j;
        dp_wdata    = cell_value;

        case (r_state)
            ST_LOAD: begin
                if (in_xfer) begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_cnt = CW'(r_cnt + 1'b1);
                    end
                    if (i_is_last) begin
                        n_last    = full ? AW'(MAX_LEN - 1) : r_cnt[AW-1:0];
                        n_i       = n_last;
                        n_fin_ovf = r_ovf || full;
                        n_cnt     = '0;
                        n_ovf     = 1'b0;
                        n_state   = ST_ROW;
                    end
                end
            end
            ST_ROW: begin
                rd_addr  = r_i;
                dp_we    = 1'b1;
                dp_waddr = r_i;
                dp_wdata = LW'(1);
                n_diag   = '0;
                n_left   = LW'(1);
                n_j      = AW'(r_i + 1'b1);
                if (r_i == r_last) begin
                    if (r_i == '0) begin
                        n_res   = LW'(1);
                        n_state = ST_FIN;
                    end else begin
                        n_i = AW'(r_i - 1'b1);
                    end
                end else begin
                    n_state = ST_FIRST;
                end
            end
            ST_FIRST: begin
                n_ci    = char_rdata;
                rd_addr = r_j;
                n_state = ST_RUN;
            end
            ST_RUN: begin
                rd_addr = AW'(r_j + 1'b1);
                dp_we   = 1'b1;
                n_left  = cell_value;
                n_diag  = dp_rdata;
                if (r_j == r_last) begin
                    if (r_i == '0) begin
                        n_res   = cell_value;
                        n_state = ST_FIN;
                    end else begin
                        n_i     = AW'(r_i - 1'b1);
                        n_state = ST_ROW;
                    end
                end else begin
                    n_j = AW'(r_j + 1'b1);
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_ovf   = r_fin_ovf;
                    if (r_res > LW'(lps_pkg::LEN_MAX)) begin
                        n_out_len = lps_pkg::PAL_W'(lps_pkg::LEN_MAX);
                    end else begin
                        n_out_len = lps_pkg::PAL_W'(r_res);
                    end
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fin_ovf <= n_fin_ovf;
        r_i       <= n_i;
        r_j       <= n_j;
        r_last    <= n_last;
        r_ci      <= n_ci;
        r_diag    <= n_diag;
        r_left    <= n_left;
        r_res     <= n_res;
        r_out_len <= n_out_len;
        r_out_ovf <= n_out_ovf;
    end

    assign o_out_valid    = r_out_valid;
    assign o_palin_length = r_out_len;
    assign o_overflowed   = r_out_ovf;

    `LPS_ASSERT_NOW(a_col_above_row, i_clk, i_rst_n, r_state == ST_RUN, r_j > r_i)
    `LPS_ASSERT_NOW(a_col_in_range, i_clk, i_rst_n, r_state == ST_RUN, r_j <= r_last)
    `LPS_ASSERT_NOW(a_ovf_only_full, i_clk, i_rst_n, r_ovf, full)
    `LPS_ASSERT_NOW(a_result_nonzero, i_clk, i_rst_n, r_out_valid, r_out_len != '0)
    `LPS_ASSERT_NEXT(a_last_starts_fill, i_clk, i_rst_n, in_xfer && i_is_last,
        r_state == ST_ROW && r_cnt == '0)

endmodule

/* bench/lps_checker.sv */
// ----------------------------------------------------------------------------
// Palindrome engine checker
// Watches both channels of the longest palindromic subsequence block. It
// stores each byte up to MAX_LEN, predicts the length and the truncation
// flag when a string ends, and compares every result transfer field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lps_checker #(
    parameter int MAX_LEN = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  lps_pkg::t_char     i_char_code,
    input  logic               i_is_last,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  lps_pkg::t_pal_len  i_palin_length,
    input  logic               i_overflowed,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        lps_pkg::t_pal_len palin_length;
        logic              overflowed;
    } t_palin_result;

    t_palin_result  palin_expect_q[$];
    lps_pkg::t_char char_seen[0:MAX_LEN-1];
    int             span_best[0:MAX_LEN-1];
    int             load_cnt;
    logic           ovf_seen;
    int             fail_total;
    t_palin_result  want;

    function automatic lps_pkg::t_pal_len predict_palin_length(input int n);
        int lo;
        int hi;
        int above;
        int corner;
        int best;
        for (lo = n - 1; lo >= 0; lo--) begin
            span_best[lo] = 1;
            corner = 0;
            for (hi = lo + 1; hi < n; hi++) begin
                above = span_best[hi];
                if (char_seen[lo] == char_seen[hi]) begin
                    span_best[hi] = corner + lps_pkg::PAIR_INC;
                end else if (span_best[hi-1] > span_best[hi]) begin
                    span_best[hi] = span_best[hi-1];
                end
                corner = above;
            end
        end
        best = span_best[n-1];
        if (best > lps_pkg::LEN_MAX) begin
            best = lps_pkg::LEN_MAX;
        end
        return lps_pkg::t_pal_len'(best);
    endfunction

    task automatic note_mismatch(input string what, input int exp_val, input int act_val);
        fail_total++;
        if (fail_total <= 10) begin
            $display("mismatch at %0t: %s expected %0d actual %0d",
                     $realtime, what, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            palin_expect_q.delete();
            load_cnt   = 0;
            ovf_seen   = 1'b0;
            fail_total = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (palin_expect_q.size() == 0) begin
                    note_mismatch("unexpected result, palin_length", -1,
                                  int'(i_palin_length));
                end else begin
                    want = palin_expect_q.pop_front();
                    if (i_palin_length !== want.palin_length) begin
                        note_mismatch("palin_length", int'(want.palin_length),
                                      int'(i_palin_length));
                    end
                    if (i_overflowed !== want.overflowed) begin
                        note_mismatch("overflowed", int'(want.overflowed),
                                      int'(i_overflowed));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (load_cnt < MAX_LEN) begin
                    char_seen[load_cnt] = i_char_code;
                    load_cnt++;
                end else begin
                    ovf_seen = 1'b1;
                end
                if (i_is_last) begin
                    want.palin_length = predict_palin_length(load_cnt);
                    want.overflowed   = ovf_seen;
                    palin_expect_q.push_back(want);
                    load_cnt = 0;
                    ovf_seen = 1'b0;
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= palin_expect_q.size();
    end

endmodule

/* bench/tb_longest_palindromic_subsequence.sv */
// ----------------------------------------------------------------------------
// Palindrome engine testbench
// Drives strings into the longest palindromic subsequence block: directed
// short strings, one string past the buffer size, then random strings of
// mostly palindromic shape under several idling patterns, and a long output
// hold-off that backs the block up. The checker beside the block predicts
// and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_longest_palindromic_subsequence;

    localparam int LPS_MAX_LEN = 1024;
    localparam int IDLE_LIMIT  = 2000000;
    localparam int HOLD_LEN    = 1500;
    localparam int TAIL_CYCLES = 64;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    lps_pkg::t_char    char_code = '0;
    logic              is_last   = 1'b0;
    logic              out_stall = 1'b0;
    logic              in_stall;
    logic              out_valid;
    lps_pkg::t_pal_len palin_length;
    logic              overflowed;

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_ack       = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    longest_palindromic_subsequence #(
        .MAX_LEN(LPS_MAX_LEN)
    ) u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_char_code    (char_code),
        .i_is_last      (is_last),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_palin_length (palin_length),
        .o_overflowed   (overflowed)
    );

    lps_checker #(
        .MAX_LEN(LPS_MAX_LEN)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_char_code    (char_code),
        .i_is_last      (is_last),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_palin_length (palin_length),
        .i_overflowed   (overflowed),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always @(posedge clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_LEN;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    task automatic send_byte(input lps_pkg::t_char c, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        is_last   <= last;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    // bytes leave from the most significant end
    task automatic send_word(input logic [63:0] word, input int len);
        int k;
        for (k = 0; k < len; k++) begin
            send_byte(word[8*(len-1-k) +: 8], k == len - 1);
        end
    endtask

    // hold the input idle until every predicted result has transferred
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic send_random_string(input int max_len);
        lps_pkg::t_char sym[4];
        lps_pkg::t_char text_bytes[64];
        int             len;
        int             style;
        int             nsym;
        int             k;
        if ($urandom_range(0, 99) < 85) begin
            len = $urandom_range(1, 5);
        end else begin
            len = $urandom_range(6, max_len);
        end
        style = $urandom_range(0, 9);
        nsym  = $urandom_range(1, 4);
        for (k = 0; k < 4; k++) begin
            sym[k] = lps_pkg::t_char'($urandom_range(0, 255));
        end
        for (k = 0; k < len; k++) begin
            if (style == 9) begin
                text_bytes[k] = lps_pkg::t_char'($urandom_range(0, 255));
            end else if (style < 6 && k >= (len + 1) / 2) begin
                text_bytes[k] = text_bytes[len-1-k];
            end else begin
                text_bytes[k] = sym[$urandom_range(0, nsym - 1)];
            end
        end
        if (style < 6 && $urandom_range(0, 99) < 30) begin
            text_bytes[$urandom_range(0, len - 1)] = lps_pkg::t_char'($urandom_range(0, 255));
        end
        for (k = 0; k < len; k++) begin
            send_byte(text_bytes[k], k == len - 1);
        end
    endtask

    initial begin
        int             ph;
        int             s;
        int             k;
        lps_pkg::t_char sym[3];

        @(posedge clk);
        @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(0, 0);
        send_word(64'h00, 1);
        send_word(64'hFF, 1);
        send_word(64'h00FF, 2);
        send_word(64'hFFFF, 2);
        send_word(64'h55AA55, 3);
        send_word(64'h1234563412, 5);
        send_word(64'h01020304, 4);
        send_word(64'h808080808080, 6);
        drain_results();

        // string past the buffer size: tail bytes are dropped and the overflow flag is set
        set_idling(51, 0);
        for (k = 0; k < 3; k++) begin
            sym[k] = lps_pkg::t_char'($urandom_range(0, 255));
        end
        for (k = 0; k < LPS_MAX_LEN + 4; k++) begin
            send_byte(sym[$urandom_range(0, 2)], k == LPS_MAX_LEN + 3);
        end
        drain_results();

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    set_idling(0, 0);
                end
                1: begin
                    set_idling(51, 0);
                end
                2: begin
                    set_idling(0, 51);
                end
                default: begin
                    set_idling(31, 31);
                end
            endcase
            for (s = 0; s < 4; s++) begin
                send_random_string(32);
            end
            drain_results();
        end

        // long output hold-off while the sender keeps offering
        set_idling(0, 0);
        hold_req <= hold_req + 1;
        for (s = 0; s < 6; s++) begin
            send_random_string(8);
        end
        drain_results();

        set_idling(31, 31);
        for (s = 0; s < 8; s++) begin
            send_random_string(32);
        end
        drain_results();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/lps_pkg.sv
rtl/lps_mem.sv
rtl/lps_cell.sv
rtl/longest_palindromic_subsequence.sv
bench/lps_checker.sv
bench/tb_longest_palindromic_subsequence.sv
